### rtl/core/llrs_pkg.sv
package llrs_pkg;

  localparam int unsigned EXT_W  = 8;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned DIR_W  = 2;
  localparam int unsigned SITE_W = 28;
  localparam int unsigned WIL_W  = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SLOT_W = 3;

  // target direction arrays
  localparam logic [DIR_W-1:0] DIR_X = 2'd0;
  localparam logic [DIR_W-1:0] DIR_Y = 2'd1;
  localparam logic [DIR_W-1:0] DIR_Z = 2'd2;
  localparam logic [DIR_W-1:0] DIR_T = 2'd3;

  // link order within a site
  localparam logic [SLOT_W-1:0] SLOT_PLUS_T  = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_MINUS_T = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_PLUS_X  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_MINUS_X = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_PLUS_Y  = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_MINUS_Y = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_PLUS_Z  = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_MINUS_Z = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_T = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic              restart;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_out;
    logic [DIR_W-1:0]  link_dir;
    logic [SITE_W-1:0] site_index;
    logic [WIL_W-1:0]  word_in_link;
    logic              field_done;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [EXT_W-1:0]     data;
  } cfg_item_t;

endpackage

### rtl/core/llrs_stream_if.sv
interface llrs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/lattice_link_reorder_scatter_unit.sv
// Link reorder and scatter for a 4D gauge field held in odd-site order.
// data_in_i  : one 64-bit word of the link stream per transaction, plus a
//              restart flag that puts the site/link counters at the start of
//              a field before that word is handled.
// data_out_o : one result per input word: the word, its target direction
//              array, the x-fastest target site index, the word's position in
//              its link and a flag on the last word of the field.
// cfg_i      : writes the four lattice extents (x, y, z, t); always ready.
//              The user must write extents only while no transaction is
//              in flight; the block does not enforce this.
// Throughput is one word per cycle while the receiver does not stall. The
// site index arithmetic runs as three registered multiply-add stages behind
// the input stage that steps the coordinate counters; the last of them is
// the output register.
// Reset clears all pipeline valids, puts the counters at the first odd site
// (z = 1) and sets every extent to 8 (clamped to the maximum extent).
// When the receiver stalls the pipeline fills up its empty stages and then
// drops ready on the input; no transaction is lost or repeated.
module lattice_link_reorder_scatter_unit
  import llrs_pkg::*;
#(
  parameter int unsigned MAX_EXTENT     = 128,
  parameter int unsigned WORDS_PER_LINK = 18
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  llrs_stream_if.sink   data_in_i,
  llrs_stream_if.source data_out_o,
  llrs_stream_if.sink   cfg_i
);

  localparam int unsigned CW   = $clog2(MAX_EXTENT);
  localparam int unsigned CAP  = ((MAX_EXTENT & ~1) < 2) ? 2 : (MAX_EXTENT & ~1);
  localparam int unsigned RST_EXT = (8 > CAP) ? CAP : 8;
  localparam int unsigned NW   = EXT_W + 1;
  localparam int unsigned WCW  = WIL_W + 1;
  localparam int unsigned AW   = EXT_W + CW;
  localparam int unsigned BW   = 2 * EXT_W + CW;
  localparam int unsigned SW   = 3 * EXT_W + CW;
  localparam int unsigned PW   = (SW > SITE_W) ? SW : SITE_W;
  localparam logic [NW-1:0]  CAP_V = NW'(CAP);
  localparam logic [WCW-1:0] WPL_V = WCW'(WORDS_PER_LINK);

  function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] v);
    logic [EXT_W-1:0] e;
    e = v & ~EXT_W'(1);
    if (e < EXT_W'(2)) e = EXT_W'(2);
    if ({1'b0, e} > CAP_V) e = CAP_V[EXT_W-1:0];
    return e;
  endfunction

  // ---------------------------------------------------------------------
  // extent registers, stored already clamped
  logic [EXT_W-1:0] nx_q, ny_q, nz_q, nt_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q <= EXT_W'(RST_EXT);
      ny_q <= EXT_W'(RST_EXT);
      nz_q <= EXT_W'(RST_EXT);
      nt_q <= EXT_W'(RST_EXT);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        REG_EXTENT_X: nx_q <= eff_extent(cfg_i.payload.data);
        REG_EXTENT_Y: ny_q <= eff_extent(cfg_i.payload.data);
        REG_EXTENT_Z: nz_q <= eff_extent(cfg_i.payload.data);
        REG_EXTENT_T: nt_q <= eff_extent(cfg_i.payload.data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // pipeline handshake: a stage loads when it is empty or moves on itself
  logic v0_q, v1_q, v2_q, v3_q;
  logic go0, go1, go2, go3;
  logic in_fire;

  assign go3 = !v3_q || data_out_o.ready;
  assign go2 = !v2_q || go3;
  assign go1 = !v1_q || go2;
  assign go0 = !v0_q || go1;
  assign data_in_i.ready = go0;
  assign in_fire = data_in_i.valid && go0;

  // ---------------------------------------------------------------------
  // coordinate counters
  logic [CW-1:0]     pos_t_q, pos_x_q, pos_y_q, pos_z_q;
  logic [SLOT_W-1:0] slot_q;
  logic [WIL_W-1:0]  wc_q;

  logic [CW-1:0]     cur_t, cur_x, cur_y, cur_z;
  logic [SLOT_W-1:0] cur_slot;
  logic [WIL_W-1:0]  cur_wc;
  logic [CW-1:0]     tgt_t, tgt_x, tgt_y, tgt_z;
  logic [DIR_W-1:0]  tgt_dir;
  logic              last_word, z_end, y_end, x_end, t_end, done;
  logic [CW-1:0]     pos_t_d, pos_x_d, pos_y_d, pos_z_d;
  logic [SLOT_W-1:0] slot_d;
  logic [WIL_W-1:0]  wc_d;

  always_comb begin
    if (data_in_i.payload.restart) begin
      cur_t = '0;
      cur_x = '0;
      cur_y = '0;
      cur_z = CW'(1);
      cur_slot = '0;
      cur_wc = '0;
    end else begin
      cur_t = pos_t_q;
      cur_x = pos_x_q;
      cur_y = pos_y_q;
      cur_z = pos_z_q;
      cur_slot = slot_q;
      cur_wc = wc_q;
    end

    tgt_t = cur_t;
    tgt_x = cur_x;
    tgt_y = cur_y;
    tgt_z = cur_z;
    unique case (cur_slot)
      SLOT_PLUS_T:  tgt_dir = DIR_T;
      SLOT_MINUS_T: begin
        tgt_dir = DIR_T;
        tgt_t = (cur_t != '0) ? cur_t - CW'(1) : CW'(nt_q - EXT_W'(1));
      end
      SLOT_PLUS_X:  tgt_dir = DIR_X;
      SLOT_MINUS_X: begin
        tgt_dir = DIR_X;
        tgt_x = (cur_x != '0) ? cur_x - CW'(1) : CW'(nx_q - EXT_W'(1));
      end
      SLOT_PLUS_Y:  tgt_dir = DIR_Y;
      SLOT_MINUS_Y: begin
        tgt_dir = DIR_Y;
        tgt_y = (cur_y != '0) ? cur_y - CW'(1) : CW'(ny_q - EXT_W'(1));
      end
      SLOT_PLUS_Z:  tgt_dir = DIR_Z;
      SLOT_MINUS_Z: begin
        tgt_dir = DIR_Z;
        tgt_z = (cur_z != '0) ? cur_z - CW'(1) : CW'(nz_q - EXT_W'(1));
      end
      default: tgt_dir = DIR_Z;
    endcase

    last_word = ({1'b0, cur_wc} + WCW'(1)) >= WPL_V;
    z_end = (NW'(cur_z) + NW'(2)) >= {1'b0, nz_q};
    y_end = (NW'(cur_y) + NW'(1)) >= {1'b0, ny_q};
    x_end = (NW'(cur_x) + NW'(1)) >= {1'b0, nx_q};
    t_end = (NW'(cur_t) + NW'(1)) >= {1'b0, nt_q};
    done  = last_word && (cur_slot == SLOT_MINUS_Z) && z_end && y_end && x_end && t_end;

    pos_t_d = cur_t;
    pos_x_d = cur_x;
    pos_y_d = cur_y;
    pos_z_d = cur_z;
    slot_d  = cur_slot;
    wc_d    = cur_wc;
    if (!last_word) begin
      wc_d = cur_wc + WIL_W'(1);
    end else begin
      wc_d = '0;
      if (cur_slot != SLOT_MINUS_Z) begin
        slot_d = cur_slot + SLOT_W'(1);
      end else begin
        slot_d = '0;
        if (!z_end) begin
          pos_z_d = cur_z + CW'(2);
        end else begin
          if (!y_end) begin
            pos_y_d = cur_y + CW'(1);
          end else begin
            pos_y_d = '0;
            if (!x_end) begin
              pos_x_d = cur_x + CW'(1);
            end else begin
              pos_x_d = '0;
              pos_t_d = t_end ? '0 : cur_t + CW'(1);
            end
          end
          // first odd z of the next (t, x, y) row
          pos_z_d = {{(CW-1){1'b0}}, ~(pos_t_d[0] ^ pos_x_d[0] ^ pos_y_d[0])};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_t_q <= '0;
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= CW'(1);
      slot_q  <= '0;
      wc_q    <= '0;
    end else if (in_fire) begin
      pos_t_q <= pos_t_d;
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
      slot_q  <= slot_d;
      wc_q    <= wc_d;
    end
  end

  // ---------------------------------------------------------------------
  // stage 0: target coordinates
  logic [WORD_W-1:0] s0_word_q;
  logic [DIR_W-1:0]  s0_dir_q;
  logic [CW-1:0]     s0_t_q, s0_x_q, s0_y_q, s0_z_q;
  logic [WIL_W-1:0]  s0_wil_q;
  logic              s0_done_q;

  // stage 1: a = z + NZ*t
  logic [WORD_W-1:0] s1_word_q;
  logic [DIR_W-1:0]  s1_dir_q;
  logic [CW-1:0]     s1_x_q, s1_y_q;
  logic [AW-1:0]     s1_a_q;
  logic [WIL_W-1:0]  s1_wil_q;
  logic              s1_done_q;

  // stage 2: b = y + NY*a
  logic [WORD_W-1:0] s2_word_q;
  logic [DIR_W-1:0]  s2_dir_q;
  logic [CW-1:0]     s2_x_q;
  logic [BW-1:0]     s2_b_q;
  logic [WIL_W-1:0]  s2_wil_q;
  logic              s2_done_q;

  // stage 3: output register, site = x + NX*b
  out_item_t         s3_q;

  logic [AW-1:0]     a_d;
  logic [BW-1:0]     b_d;
  logic [PW-1:0]     site_d;

  assign a_d    = AW'(s0_z_q) + AW'(nz_q) * AW'(s0_t_q);
  assign b_d    = BW'(s1_y_q) + BW'(ny_q) * BW'(s1_a_q);
  assign site_d = PW'(s2_x_q) + PW'(nx_q) * PW'(s2_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (go0) v0_q <= data_in_i.valid;
      if (go1) v1_q <= v0_q;
      if (go2) v2_q <= v1_q;
      if (go3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_word_q <= data_in_i.payload.data_word;
      s0_dir_q  <= tgt_dir;
      s0_t_q    <= tgt_t;
      s0_x_q    <= tgt_x;
      s0_y_q    <= tgt_y;
      s0_z_q    <= tgt_z;
      s0_wil_q  <= cur_wc;
      s0_done_q <= done;
    end
    if (go1 && v0_q) begin
      s1_word_q <= s0_word_q;
      s1_dir_q  <= s0_dir_q;
      s1_x_q    <= s0_x_q;
      s1_y_q    <= s0_y_q;
      s1_a_q    <= a_d;
      s1_wil_q  <= s0_wil_q;
      s1_done_q <= s0_done_q;
    end
    if (go2 && v1_q) begin
      s2_word_q <= s1_word_q;
      s2_dir_q  <= s1_dir_q;
      s2_x_q    <= s1_x_q;
      s2_b_q    <= b_d;
      s2_wil_q  <= s1_wil_q;
      s2_done_q <= s1_done_q;
    end
    if (go3 && v2_q) begin
      s3_q.word_out     <= s2_word_q;
      s3_q.link_dir     <= s2_dir_q;
      s3_q.site_index   <= site_d[SITE_W-1:0];
      s3_q.word_in_link <= s2_wil_q;
      s3_q.field_done   <= s2_done_q;
    end
  end

  assign data_out_o.valid   = v3_q;
  assign data_out_o.payload = s3_q;

endmodule
